>>> rtl/bmppk_pkg.sv
package bmppk_pkg;

    // Field and counter widths
    localparam int unsigned SIZE_W  = 13;
    localparam int unsigned COUNT_W = 12;
    localparam int unsigned IDX_W   = 2;

    // Largest row length and image height taken from the size registers
    localparam logic [SIZE_W-1:0] MAX_WIDTH  = 13'd4096;
    localparam logic [SIZE_W-1:0] MAX_HEIGHT = 13'd4096;

    // Configuration register indexes
    localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [IDX_W-1:0] REG_DEPTH_MODE   = 2'd2;

    // Depth mode codes
    localparam logic DEPTH_4BPP = 1'b0;
    localparam logic DEPTH_8BPP = 1'b1;

    // Bytes owed for one accepted pixel: an optional data byte, then padding
    typedef struct packed {
        logic [7:0] data;
        logic       has_data;
        logic [1:0] pad;
        logic       row_last;
        logic       img_end;
    } t_job;

    // Map a zero size to one and saturate above the maximum
    function automatic logic [SIZE_W-1:0] clamp_size(
        input logic [SIZE_W-1:0] v,
        input logic [SIZE_W-1:0] max_v
    );
        logic [SIZE_W-1:0] r;
        r = v;
        if (v == '0) begin
            r = {{(SIZE_W-1){1'b0}}, 1'b1};
        end else if (v > max_v) begin
            r = max_v;
        end
        return r;
    endfunction

endpackage

>>> rtl/bmppk_pix_if.sv
interface bmppk_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel;

    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

>>> rtl/bmppk_byte_if.sv
interface bmppk_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       row_end;
    logic       image_end;

    modport source (output valid, output out_byte, output row_end, output image_end,
                    input ready);
    modport sink   (input valid, input out_byte, input row_end, input image_end,
                    output ready);
endinterface

>>> rtl/bmppk_emit.sv
module bmppk_emit
    import bmppk_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  t_job                i_job,
    output logic                o_can_load,
    bmppk_byte_if.source        o_byte
);

    logic       r_valid;
    t_job       r_job;
    logic       n_valid;
    t_job       n_job;
    logic       s_last_byte;
    logic       s_xfer;

    // The byte on offer closes the job when no padding follows it
    assign s_last_byte = r_job.has_data ? (r_job.pad == 2'd0) : (r_job.pad == 2'd1);
    assign s_xfer      = r_valid && o_byte.ready;
    assign o_can_load  = !r_valid || (s_last_byte && o_byte.ready);

    // Drive the output channel from the job register
    assign o_byte.valid     = r_valid;
    assign o_byte.out_byte  = r_job.has_data ? r_job.data : 8'h00;
    assign o_byte.row_end   = r_job.row_last && s_last_byte;
    assign o_byte.image_end = r_job.row_last && s_last_byte && r_job.img_end;

    // Advance through the job one byte per transfer, take a new job when free
    always_comb begin
        n_valid = r_valid;
        n_job   = r_job;
        if (s_xfer) begin
            if (s_last_byte) begin
                n_valid = 1'b0;
            end else if (r_job.has_data) begin
                n_job.has_data = 1'b0;
            end else begin
                n_job.pad = r_job.pad - 2'd1;
            end
        end
        if (i_load) begin
            n_valid = 1'b1;
            n_job   = i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_job <= n_job;
    end

`ifndef ASSERT_OFF
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> (!r_valid || (s_last_byte && o_byte.ready)))
        else $error("job loaded over one still in progress");

    a_pad_only_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !r_job.has_data) |-> (r_job.pad != 2'd0))
        else $error("empty job on offer");

    a_job_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_xfer && !s_last_byte) |=> (r_valid && !r_job.has_data))
        else $error("job dropped before its last byte");

    a_image_end_on_row_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && o_byte.image_end) |-> o_byte.row_end)
        else $error("image end without row end");
`endif

endmodule

>>> rtl/bmp_pixel_row_packer_core.sv
// Channel    Dir   Payload                          Transfer
// i_pix      in    pixel[7:0]                       valid && ready
// o_byte     out   out_byte[7:0] row_end image_end  valid && ready
// i_cfg_*    in    i_cfg_idx[1:0] i_cfg_data[12:0]  i_cfg_we high
//
// One pixel per cycle is accepted while its bytes have room; each pixel is folded
// into the row state in the cycle it is taken and its bytes are queued in one job
// register. A row-closing pixel owes up to four bytes (data plus zero padding),
// so the input is held while the job register drains.
// In 4-bit mode an even pixel that does not close a row produces no byte and is
// taken even while a job waits. Stalls on o_byte hold the job and, once the job
// register is full, i_pix. Reset (synchronous) clears counters and the job.
module bmp_pixel_row_packer_core
    import bmppk_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [IDX_W-1:0]    i_cfg_idx,
    input  logic [SIZE_W-1:0]   i_cfg_data,
    bmppk_pix_if.sink           i_pix,
    bmppk_byte_if.source        o_byte
);

    logic [SIZE_W-1:0]  r_width;
    logic [SIZE_W-1:0]  r_height;
    logic               r_depth;
    logic [COUNT_W-1:0] r_column;
    logic [COUNT_W-1:0] r_row;
    logic [3:0]         r_held;
    logic [1:0]         r_mod4;

    logic [SIZE_W-1:0]  s_w_eff;
    logic [SIZE_W-1:0]  s_h_eff;
    logic               s_last;
    logic               s_img_end;
    logic               s_odd;
    logic               s_emit;
    logic [1:0]         s_mod4;
    logic               s_can_load;
    logic               s_accept;
    t_job               s_job;

    // Effective sizes and row position of the pixel on offer
    assign s_w_eff   = clamp_size(r_width, MAX_WIDTH);
    assign s_h_eff   = clamp_size(r_height, MAX_HEIGHT);
    assign s_last    = ({1'b0, r_column} + {{(SIZE_W-1){1'b0}}, 1'b1}) >= s_w_eff;
    assign s_img_end = ({1'b0, r_row} + {{(SIZE_W-1){1'b0}}, 1'b1}) >= s_h_eff;
    assign s_odd     = r_column[0];
    assign s_emit    = s_odd || (r_depth == DEPTH_8BPP) || s_last;
    assign s_mod4    = r_mod4 + {1'b0, s_emit};

    // Build the job: data byte, then padding up to a four-byte boundary
    always_comb begin
        s_job.has_data = 1'b1;
        s_job.row_last = s_last;
        s_job.img_end  = s_img_end;
        s_job.pad      = s_last ? (2'd0 - s_mod4) : 2'd0;
        if (r_depth == DEPTH_8BPP) begin
            s_job.data = i_pix.pixel;
        end else if (s_odd) begin
            s_job.data = {r_held, i_pix.pixel[3:0]};
        end else begin
            s_job.data = {i_pix.pixel[3:0], 4'h0};
        end
    end

    // Take a pixel when its bytes have room, or when it owes none
    assign i_pix.ready = !s_emit || s_can_load;
    assign s_accept    = i_pix.valid && i_pix.ready;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= {{(SIZE_W-1){1'b0}}, 1'b1};
            r_height <= {{(SIZE_W-1){1'b0}}, 1'b1};
            r_depth  <= DEPTH_8BPP;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_IMAGE_WIDTH:  r_width  <= i_cfg_data;
                REG_IMAGE_HEIGHT: r_height <= i_cfg_data;
                REG_DEPTH_MODE:   r_depth  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Advance row state on every accepted pixel
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_column <= '0;
            r_row    <= '0;
            r_held   <= 4'h0;
            r_mod4   <= 2'd0;
        end else if (s_accept) begin
            if (!s_odd) begin
                r_held <= i_pix.pixel[3:0];
            end
            if (s_last) begin
                r_column <= '0;
                r_row    <= s_img_end ? '0 : r_row + {{(COUNT_W-1){1'b0}}, 1'b1};
                r_mod4   <= 2'd0;
            end else begin
                r_column <= r_column + {{(COUNT_W-1){1'b0}}, 1'b1};
                r_mod4   <= s_mod4;
            end
        end
    end

    bmppk_emit u_emit (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (s_accept && s_emit),
        .i_job      (s_job),
        .o_can_load (s_can_load),
        .o_byte     (o_byte)
    );

endmodule
